FILE: src/gregorian_date_difference_macros.svh
// Assertion macros shared by the date difference RTL.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef GREGORIAN_DATE_DIFFERENCE_MACROS_SVH
`define GREGORIAN_DATE_DIFFERENCE_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define GDD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("date difference check failed");

// Next-cycle implication, disabled while reset is active
`define GDD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("date difference check failed");

`endif

FILE: src/gdd_pkg.sv
// Shared types, widths, constants and calendar tables for the date difference block.
// No dependencies.
package gdd_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int DIFF_W   = 22;
  localparam int DNUM_W   = 23;  // day number of any 14-bit year fits in 23 bits
  localparam int MDAYS_W  = 9;   // days before month plus leap day plus day
  localparam int Q100_W   = 8;   // year / 100 for a 14-bit year
  localparam int PROD_W   = 29;  // year times reciprocal
  localparam int RECIP_SH = 21;
  localparam logic [14:0] RECIP_100 = 15'd20972;  // ceil(2^21 / 100)

  localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

  localparam logic signed [1:0] ORD_LATER   = 2'sb01;
  localparam logic signed [1:0] ORD_EQUAL   = 2'sb00;
  localparam logic signed [1:0] ORD_EARLIER = 2'sb11;

  // Per-stage advance enables of the four pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // What one date lane hands to the merge stage
  typedef struct packed {
    logic               valid;
    logic               leap;
    logic [DNUM_W-1:0]  year_days;
    logic [MDAYS_W-1:0] month_days;
  } lane_res_t;

  // Month length in a common year, zero for codes that are not months
  function automatic logic [4:0] days_in_month(input logic [MONTH_W-1:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of the whole months before month m in a common year
  function automatic logic [MDAYS_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [MDAYS_W-1:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: src/gdd_lane.sv
// One date lane: leap year, validity and closed-form day number in two stages.
// Depends on gdd_pkg.
module gdd_lane (
  input  logic                        clk_i,
  input  gdd_pkg::stage_en_t          en_i,
  input  logic [gdd_pkg::DAY_W-1:0]   day_i,
  input  logic [gdd_pkg::MONTH_W-1:0] month_i,
  input  logic [gdd_pkg::YEAR_W-1:0]  year_i,
  output gdd_pkg::lane_res_t          res_o
);

  // Stage 1: year / 100 by reciprocal multiply
  logic [gdd_pkg::PROD_W-1:0]  prod;
  logic [gdd_pkg::Q100_W-1:0]  q100_q;
  logic [gdd_pkg::YEAR_W-1:0]  year_q;
  logic [gdd_pkg::MONTH_W-1:0] month_q;
  logic [gdd_pkg::DAY_W-1:0]   day_q;

  assign prod = gdd_pkg::PROD_W'(year_i) * gdd_pkg::PROD_W'(gdd_pkg::RECIP_100);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      q100_q  <= prod[gdd_pkg::PROD_W-1:gdd_pkg::RECIP_SH];
      year_q  <= year_i;
      month_q <= month_i;
      day_q   <= day_i;
    end
  end

  // Stage 2: remainders, leap, validity and the two partial day counts
  logic [14:0]                   q_times_100;
  logic                          div100;
  logic                          div400;
  logic                          leap;
  logic                          month_ok;
  logic [4:0]                    len;
  logic                          valid;
  logic [gdd_pkg::DNUM_W-1:0]    y4;
  logic [gdd_pkg::DNUM_W-1:0]    y100;
  logic [gdd_pkg::DNUM_W-1:0]    y400;
  logic [gdd_pkg::DNUM_W-1:0]    year_days;
  logic [gdd_pkg::MDAYS_W-1:0]   month_days;

  always_comb begin
    q_times_100 = 15'(q100_q) * 15'd100;
    div100      = (15'(year_q) == q_times_100);
    div400      = div100 && (q100_q[1:0] == 2'b00);
    leap        = ((year_q[1:0] == 2'b00) && !div100) || div400;

    month_ok = (month_q >= 4'd1) && (month_q <= 4'd12);
    len      = gdd_pkg::days_in_month(month_q);
    if (leap && (month_q == 4'd2)) begin
      len = 5'd29;
    end
    valid = month_ok && (day_q != '0) && (day_q <= len);

    // ceil(y/4) - ceil(y/100) + ceil(y/400)
    y4   = gdd_pkg::DNUM_W'(year_q[gdd_pkg::YEAR_W-1:2]) + gdd_pkg::DNUM_W'(year_q[1:0] != 2'b00);
    y100 = gdd_pkg::DNUM_W'(q100_q) + gdd_pkg::DNUM_W'(!div100);
    y400 = gdd_pkg::DNUM_W'(q100_q[gdd_pkg::Q100_W-1:2]) + gdd_pkg::DNUM_W'(!div400);
    year_days = gdd_pkg::DNUM_W'(year_q) * gdd_pkg::DNUM_W'(365) + y4 - y100 + y400;

    month_days = gdd_pkg::days_before_month(month_q)
               + gdd_pkg::MDAYS_W'(leap && (month_q > 4'd2))
               + gdd_pkg::MDAYS_W'(day_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      res_o.valid      <= valid;
      res_o.leap       <= leap;
      res_o.year_days  <= year_days;
      res_o.month_days <= month_days;
    end
  end

endmodule

FILE: src/gdd_merge.sv
// Merge stage: combines both lanes into day numbers, then the saturated difference.
// Depends on gdd_pkg.
module gdd_merge (
  input  logic                             clk_i,
  input  gdd_pkg::stage_en_t               en_i,
  input  gdd_pkg::lane_res_t               first_i,
  input  gdd_pkg::lane_res_t               second_i,
  input  logic signed [1:0]                order_i,
  output logic                             valid_first_o,
  output logic                             valid_second_o,
  output logic                             leap_first_o,
  output logic                             leap_second_o,
  output logic signed [1:0]                order_o,
  output logic [gdd_pkg::DIFF_W-1:0]       day_difference_o
);

  // Stage 3: full day numbers
  logic [gdd_pkg::DNUM_W-1:0] n1_q, n2_q;
  logic                       v1_q, v2_q, l1_q, l2_q;
  logic signed [1:0]          ord_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      n1_q  <= first_i.year_days + gdd_pkg::DNUM_W'(first_i.month_days);
      n2_q  <= second_i.year_days + gdd_pkg::DNUM_W'(second_i.month_days);
      v1_q  <= first_i.valid;
      v2_q  <= second_i.valid;
      l1_q  <= first_i.leap;
      l2_q  <= second_i.leap;
      ord_q <= order_i;
    end
  end

  // Stage 4: absolute difference with saturation, output register
  logic [gdd_pkg::DNUM_W-1:0] diff;
  logic [gdd_pkg::DIFF_W-1:0] diff_sat;

  always_comb begin
    diff = (n1_q >= n2_q) ? (n1_q - n2_q) : (n2_q - n1_q);
    if (!(v1_q && v2_q)) begin
      diff_sat = '0;
    end else if (diff[gdd_pkg::DNUM_W-1]) begin
      diff_sat = gdd_pkg::DIFF_MAX;
    end else begin
      diff_sat = diff[gdd_pkg::DIFF_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      valid_first_o    <= v1_q;
      valid_second_o   <= v2_q;
      leap_first_o     <= l1_q;
      leap_second_o    <= l2_q;
      order_o          <= ord_q;
      day_difference_o <= diff_sat;
    end
  end

endmodule

FILE: src/gregorian_date_difference.sv
// Gregorian date pair difference: two date lanes, a merge stage, four pipeline stages.
// Stages 1 to 4 are registered; one request per cycle while in_stall_o is low.
// The year / 100 reciprocal multiply in each lane sets stage 1; the 23-bit day
// number subtract sets stage 4. Stages collapse bubbles, so a stalled output
// still lets requests fill empty stages. Reset clears the stage valid bits only.
// Depends on gdd_pkg, gdd_lane, gdd_merge and the macros header.
`include "gregorian_date_difference_macros.svh"

module gregorian_date_difference (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [gdd_pkg::DAY_W-1:0]         day_first_i,
  input  logic [gdd_pkg::MONTH_W-1:0]       month_first_i,
  input  logic [gdd_pkg::YEAR_W-1:0]        year_first_i,
  input  logic [gdd_pkg::DAY_W-1:0]         day_second_i,
  input  logic [gdd_pkg::MONTH_W-1:0]       month_second_i,
  input  logic [gdd_pkg::YEAR_W-1:0]        year_second_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              valid_first_o,
  output logic                              valid_second_o,
  output logic                              leap_first_o,
  output logic                              leap_second_o,
  output logic signed [1:0]                 order_o,
  output logic [gdd_pkg::DIFF_W-1:0]        day_difference_o
);

  // Stage valid bits and advance enables
  logic [3:0]         v_q, v_d;
  gdd_pkg::stage_en_t en;

  always_comb begin
    en.s4 = !v_q[3] || !out_stall_i;
    en.s3 = !v_q[2] || en.s4;
    en.s2 = !v_q[1] || en.s3;
    en.s1 = !v_q[0] || en.s2;
    v_d[0] = en.s1 ? in_valid_i : v_q[0];
    v_d[1] = en.s2 ? v_q[0]     : v_q[1];
    v_d[2] = en.s3 ? v_q[1]     : v_q[2];
    v_d[3] = en.s4 ? v_q[2]     : v_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !en.s1;
  assign out_valid_o = v_q[3];

  // Lexicographic order on the raw fields (year, month, day)
  localparam int KEY_W = gdd_pkg::YEAR_W + gdd_pkg::MONTH_W + gdd_pkg::DAY_W;
  logic [KEY_W-1:0]  key_first, key_second;
  logic signed [1:0] order;
  logic signed [1:0] ord1_q, ord2_q;

  always_comb begin
    key_first  = {year_first_i, month_first_i, day_first_i};
    key_second = {year_second_i, month_second_i, day_second_i};
    priority if (key_first > key_second) begin
      order = gdd_pkg::ORD_LATER;
    end else if (key_first < key_second) begin
      order = gdd_pkg::ORD_EARLIER;
    end else begin
      order = gdd_pkg::ORD_EQUAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      ord1_q <= order;
    end
    if (en.s2) begin
      ord2_q <= ord1_q;
    end
  end

  // Two date lanes
  gdd_pkg::lane_res_t res_first, res_second;

  gdd_lane u_lane_first (
    .clk_i   (clk_i),
    .en_i    (en),
    .day_i   (day_first_i),
    .month_i (month_first_i),
    .year_i  (year_first_i),
    .res_o   (res_first)
  );

  gdd_lane u_lane_second (
    .clk_i   (clk_i),
    .en_i    (en),
    .day_i   (day_second_i),
    .month_i (month_second_i),
    .year_i  (year_second_i),
    .res_o   (res_second)
  );

  // Merge of both lanes into the result
  gdd_merge u_merge (
    .clk_i            (clk_i),
    .en_i             (en),
    .first_i          (res_first),
    .second_i         (res_second),
    .order_i          (ord2_q),
    .valid_first_o    (valid_first_o),
    .valid_second_o   (valid_second_o),
    .leap_first_o     (leap_first_o),
    .leap_second_o    (leap_second_o),
    .order_o          (order_o),
    .day_difference_o (day_difference_o)
  );

  // A nonzero difference needs two valid dates
  `GDD_ASSERT_IMPL(a_diff_needs_valid, out_valid_o && (day_difference_o != '0), valid_first_o && valid_second_o)
  // Equal valid dates are zero days apart
  `GDD_ASSERT_IMPL(a_equal_zero_diff, out_valid_o && (order_o == gdd_pkg::ORD_EQUAL) && valid_first_o && valid_second_o, day_difference_o == '0)
  // An empty output stage never blocks requests
  `GDD_ASSERT_IMPL(a_no_stall_when_empty, !out_valid_o, !in_stall_o)
  // A stalled result stays presented
  `GDD_ASSERT_NEXT(a_result_held, out_valid_o && out_stall_i, out_valid_o)

endmodule
